// ----- sv/pmd_pkg.sv -----
package pmd_pkg;

  localparam int ACTION_W   = 2;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DRIVE_W    = 8;
  localparam int DUTY_W     = 11;

  localparam logic [ACTION_W-1:0] ACT_PULSE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CTRL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ZERO  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd4;

  typedef enum logic [1:0] {
    KIND_PULSE,
    KIND_CTRL,
    KIND_ZERO,
    KIND_NOP
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic signed [POS_W-1:0]  target;
  } queue_entry_t;

  typedef struct packed {
    logic                     valid;
    item_kind_t               kind;
    logic signed [POS_W-1:0]  target;
  } queue_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_P,
    BK_MUL_D,
    BK_MUL_IL,
    BK_MUL_IH,
    BK_ACC,
    BK_FIN
  } back_state_t;

endpackage

// ----- sv/pmd_front.sv -----
module pmd_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pmd_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [pmd_pkg::POS_W-1:0]    in_target,
  output pmd_pkg::queue_head_t                head,
  input  logic                                pop
);
  import pmd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  item_kind_t       in_kind;

  always_comb begin
    unique case (in_action)
      ACT_PULSE: in_kind = KIND_PULSE;
      ACT_CTRL:  in_kind = KIND_CTRL;
      ACT_ZERO:  in_kind = KIND_ZERO;
      default:   in_kind = KIND_NOP;
    endcase
  end

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;

  assign head.valid  = (count_r != '0);
  assign head.kind   = entries_r[rd_ptr_r].kind;
  assign head.target = entries_r[rd_ptr_r].target;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= '{kind: in_kind, target: in_target};
    end
  end

endmodule

// ----- sv/pmd_back.sv -----
module pmd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  pmd_pkg::queue_head_t                head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pmd_pkg::DRIVE_W-1:0]  out_drive,
  output logic [pmd_pkg::DUTY_W-1:0]          out_duty_reverse,
  output logic [pmd_pkg::DUTY_W-1:0]          out_duty_forward,
  output logic                                out_moving_forward,
  output logic                                out_settled,
  output logic signed [pmd_pkg::POS_W-1:0]    out_position_now
);
  import pmd_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      sat48 = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  // configuration
  logic signed [15:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [15:0]        pulse_step_r;
  logic [30:0]        dead_band_r;

  // servo state
  back_state_t        state_r, state_nxt;
  logic signed [31:0] position_r, position_nxt;
  logic signed [47:0] error_sum_r, error_sum_nxt;
  logic signed [31:0] last_error_r, last_error_nxt;
  logic               forward_r, forward_nxt;
  logic signed [7:0]  drive_r, drive_nxt;

  // control-step datapath
  logic signed [32:0] derr_r, derr_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [7:0]  out_drive_r;
  logic [10:0]        out_duty_rev_r, out_duty_fwd_r;
  logic               out_fwd_r, out_settled_r;
  logic signed [31:0] out_pos_r;

  logic signed [32:0] pos_ext, step_ext, pulse_sum;
  logic signed [31:0] pulse_pos;
  logic signed [32:0] err_diff;
  logic signed [31:0] err_sat;
  logic [31:0]        err_mag;
  logic               outside;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_sat;
  logic signed [32:0] derr;
  logic signed [63:0] acc_adj;
  logic signed [47:0] quot;
  logic signed [7:0]  drive_fin;
  logic [6:0]         drive_mag;
  logic [10:0]        duty;
  logic               out_free;
  logic               emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= 16'sd200;
      integ_gain_r <= 16'sd0;
      deriv_gain_r <= 16'sd0;
      pulse_step_r <= 16'd367;
      dead_band_r  <= 31'd9830;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[15:0];
        CFG_INTEG_GAIN: integ_gain_r <= cfg_wdata[15:0];
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[15:0];
        CFG_PULSE_STEP: pulse_step_r <= cfg_wdata[15:0];
        CFG_DEAD_BAND:  dead_band_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // pulse move
  assign pos_ext   = {position_r[31], position_r};
  assign step_ext  = {17'b0, pulse_step_r};
  assign pulse_sum = forward_r ? pos_ext + step_ext : pos_ext - step_ext;
  assign pulse_pos = sat32(pulse_sum);

  // error, integral, deadband
  assign err_diff = {head.target[31], head.target} - pos_ext;
  assign err_sat  = sat32(err_diff);
  assign err_mag  = err_sat[31] ? (~err_sat + 32'd1) : err_sat;
  assign outside  = (err_mag > {1'b0, dead_band_r});
  assign sum_wide = {error_sum_r[47], error_sum_r} + {{17{err_sat[31]}}, err_sat};
  assign sum_sat  = sat48(sum_wide);
  assign derr     = {err_sat[31], err_sat} - {last_error_r[31], last_error_r};

  // shared multiplier: one product per cycle, integral term split into two halves
  always_comb begin
    case (state_r)
      BK_MUL_P: begin
        mul_a = prop_gain_r;
        mul_b = {last_error_r[31], last_error_r};
      end
      BK_MUL_D: begin
        mul_a = deriv_gain_r;
        mul_b = derr_r;
      end
      BK_MUL_IL: begin
        mul_a = integ_gain_r;
        mul_b = {9'b0, error_sum_r[23:0]};
      end
      BK_MUL_IH: begin
        mul_a = integ_gain_r;
        mul_b = {{9{error_sum_r[47]}}, error_sum_r[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // truncate toward zero, then clamp
  assign acc_adj = acc_r + (acc_r[63] ? 64'sd65535 : 64'sd0);
  assign quot    = acc_adj[63:16];

  always_comb begin
    if (quot > 48'sd100) begin
      drive_fin = 8'sd100;
    end else if (quot < -48'sd100) begin
      drive_fin = -8'sd100;
    end else begin
      drive_fin = quot[7:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    position_nxt   = position_r;
    error_sum_nxt  = error_sum_r;
    last_error_nxt = last_error_r;
    forward_nxt    = forward_r;
    drive_nxt      = drive_r;
    derr_nxt       = derr_r;
    acc_nxt        = acc_r;
    pop            = 1'b0;
    emit           = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_PULSE: begin
              position_nxt = pulse_pos;
              emit         = 1'b1;
            end
            KIND_ZERO: begin
              position_nxt = '0;
              drive_nxt    = '0;
              emit         = 1'b1;
            end
            KIND_CTRL: begin
              error_sum_nxt  = sum_sat;
              last_error_nxt = err_sat;
              derr_nxt       = derr;
              if (outside) begin
                state_nxt = BK_MUL_P;
              end else begin
                drive_nxt   = '0;
                forward_nxt = 1'b1;
                emit        = 1'b1;
              end
            end
            KIND_NOP: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_MUL_P: begin
        state_nxt = BK_MUL_D;
      end
      BK_MUL_D: begin
        acc_nxt   = 64'(prod_r);
        state_nxt = BK_MUL_IL;
      end
      BK_MUL_IL: begin
        acc_nxt   = acc_r + 64'(prod_r);
        state_nxt = BK_MUL_IH;
      end
      BK_MUL_IH: begin
        acc_nxt   = acc_r + 64'(prod_r);
        state_nxt = BK_ACC;
      end
      BK_ACC: begin
        // upper half of the integral term carries weight 2^24
        acc_nxt   = acc_r + (64'(prod_r) <<< 24);
        state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          drive_nxt   = drive_fin;
          forward_nxt = !drive_fin[7];
          emit        = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign drive_mag     = drive_nxt[7] ? 7'(-drive_nxt) : drive_nxt[6:0];
  assign duty          = {drive_mag, 4'b0} + {2'b0, drive_mag, 2'b0};
  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      position_r   <= '0;
      error_sum_r  <= '0;
      last_error_r <= '0;
      forward_r    <= 1'b1;
      drive_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      position_r   <= position_nxt;
      error_sum_r  <= error_sum_nxt;
      last_error_r <= last_error_nxt;
      forward_r    <= forward_nxt;
      drive_r      <= drive_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    derr_r <= derr_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (emit) begin
      out_drive_r    <= drive_nxt;
      out_duty_rev_r <= drive_nxt[7] ? duty : 11'd0;
      out_duty_fwd_r <= drive_nxt[7] ? 11'd0 : duty;
      out_fwd_r      <= forward_nxt;
      out_settled_r  <= (drive_nxt == 8'sd0);
      out_pos_r      <= position_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive          = out_drive_r;
  assign out_duty_reverse   = out_duty_rev_r;
  assign out_duty_forward   = out_duty_fwd_r;
  assign out_moving_forward = out_fwd_r;
  assign out_settled        = out_settled_r;
  assign out_position_now   = out_pos_r;

endmodule

// ----- sv/position_pid_motor_drive.sv -----
// An encoder pulse, zero or unused action, or a control step inside the deadband, ends in idle;
// one outside it runs BK_MUL_P, BK_MUL_D, BK_MUL_IL, BK_MUL_IH, BK_ACC and BK_FIN in turn.
// Throughput: one pulse or zero item per cycle while the result register is free; a control step
// outside the deadband holds the back end while it runs four products through one multiplier.
// The input queue (QUEUE_DEPTH entries) keeps taking items while the back end works.
// Reset (rst_n low, synchronous): queue empty, position, integral, last error and drive zero,
// direction forward, gains, step and deadband back to their default values.
module position_pid_motor_drive #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pmd_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [pmd_pkg::POS_W-1:0]    in_target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pmd_pkg::DRIVE_W-1:0]  out_drive,
  output logic [pmd_pkg::DUTY_W-1:0]          out_duty_reverse,
  output logic [pmd_pkg::DUTY_W-1:0]          out_duty_forward,
  output logic                                out_moving_forward,
  output logic                                out_settled,
  output logic signed [pmd_pkg::POS_W-1:0]    out_position_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import pmd_pkg::*;

  queue_head_t head;
  logic        pop;

  pmd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_target (in_target),
    .head      (head),
    .pop       (pop)
  );

  pmd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive          (out_drive),
    .out_duty_reverse   (out_duty_reverse),
    .out_duty_forward   (out_duty_forward),
    .out_moving_forward (out_moving_forward),
    .out_settled        (out_settled),
    .out_position_now   (out_position_now)
  );

endmodule

// ----- sim/position_pid_motor_drive_test.sv -----
module position_pid_motor_drive_test;
  import pmd_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_IDLE = 2'd3;

  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -64'sd2147483648;
  localparam longint SUM_MAX     = 64'sd140737488355327;
  localparam longint SUM_MIN     = -64'sd140737488355328;
  localparam longint DRIVE_MAX   = 100;
  localparam longint DUTY_SCALE  = 20;
  localparam longint Q_ONE       = 65536;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int     DRAIN_GAP   = 12;
  localparam int     HOLD_CYCLES = 300;
  localparam int     IDLE_PCT    = 11;
  localparam int     PHASE_ITEMS = 210;

  typedef struct {
    logic [ACTION_W-1:0]     action;
    logic signed [POS_W-1:0] target;
  } servo_cmd_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic [DUTY_W-1:0]         duty_rev;
    logic [DUTY_W-1:0]         duty_fwd;
    logic                      fwd;
    logic                      settled;
    logic signed [POS_W-1:0]   pos;
  } servo_report_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ACTION_W-1:0]       in_action = ACT_PULSE;
  logic signed [POS_W-1:0]   in_target = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;
  logic [DUTY_W-1:0]         out_duty_reverse;
  logic [DUTY_W-1:0]         out_duty_forward;
  logic                      out_moving_forward;
  logic                      out_settled;
  logic signed [POS_W-1:0]   out_position_now;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // servo state and gains as the block should hold them
  longint g_kp = 200;
  longint g_ki = 0;
  longint g_kd = 0;
  longint g_step = 367;
  longint g_band = 9830;
  longint m_pos = 0;
  longint m_isum = 0;
  longint m_last_err = 0;
  longint m_drive = 0;
  bit     m_fwd = 1'b1;

  servo_cmd_t    cmds_waiting[$];
  servo_report_t reports_due[$];
  int            cmds_queued = 0;
  int            reports_checked = 0;
  int            errors = 0;
  longint        cycles = 0;
  bit            in_xfer = 1'b0;
  bit            calm = 1'b0;
  bit            hold_go = 1'b0;
  bit            hold_seen = 1'b0;
  int            hold_left = 0;

  position_pid_motor_drive dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint limit(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic servo_report_t step_servo(input logic [ACTION_W-1:0] act,
                                               input logic signed [POS_W-1:0] tgt);
    longint err;
    longint mag;
    longint acc;
    longint duty;
    servo_report_t r;
    case (act)
      ACT_PULSE: begin
        m_pos = limit(m_fwd ? m_pos + g_step : m_pos - g_step, POS_MIN, POS_MAX);
      end
      ACT_CTRL: begin
        err = limit(longint'(tgt) - m_pos, POS_MIN, POS_MAX);
        mag = err < 0 ? -err : err;
        m_isum = limit(m_isum + err, SUM_MIN, SUM_MAX);
        m_drive = 0;
        if (mag > g_band) begin
          acc = g_kp * err + g_ki * m_isum + g_kd * (err - m_last_err);
          // division truncates toward zero
          m_drive = limit(acc / Q_ONE, -DRIVE_MAX, DRIVE_MAX);
        end
        m_fwd = m_drive >= 0;
        m_last_err = err;
      end
      ACT_ZERO: begin
        m_pos = 0;
        m_drive = 0;
      end
      default: ;
    endcase
    duty = m_drive * DUTY_SCALE;
    r.drive    = m_drive[DRIVE_W-1:0];
    r.duty_rev = DUTY_W'(duty < 0 ? -duty : 64'sd0);
    r.duty_fwd = DUTY_W'(duty >= 0 ? duty : 64'sd0);
    r.fwd      = m_fwd;
    r.settled  = m_drive == 0;
    r.pos      = POS_W'(m_pos);
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // feed commands, holding each one until its transfer
  always @(negedge clk) begin : drive_cmds
    servo_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (cmds_waiting.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        c = cmds_waiting.pop_front();
        in_valid  <= 1'b1;
        in_action <= c.action;
        in_target <= c.target;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : accept_reports
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : track
    servo_report_t want;
    in_xfer <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no command outstanding, position %0d",
                 $time, out_position_now);
      end else begin
        want = reports_due.pop_front();
        check_field("drive", $signed(want.drive), $signed(out_drive));
        check_field("duty_reverse", want.duty_rev, out_duty_reverse);
        check_field("duty_forward", want.duty_fwd, out_duty_forward);
        check_field("moving_forward", want.fwd, out_moving_forward);
        check_field("settled", want.settled, out_settled);
        check_field("position_now", $signed(want.pos), $signed(out_position_now));
        reports_checked++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      reports_due.push_back(step_servo(in_action, in_target));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d results seen", $time, reports_checked, cmds_queued);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_cmd(input logic [ACTION_W-1:0] a, input logic signed [POS_W-1:0] t);
    servo_cmd_t c;
    c.action = a;
    c.target = t;
    cmds_waiting.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_repeat(input logic [ACTION_W-1:0] a, input logic signed [POS_W-1:0] t,
                             input int n);
    for (int i = 0; i < n; i++) push_cmd(a, t);
  endtask

  task automatic push_random(input int n);
    int r;
    logic [ACTION_W-1:0] a;
    logic signed [POS_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      a = r < 35 ? ACT_PULSE : r < 80 ? ACT_CTRL : r < 93 ? ACT_ZERO : ACT_IDLE;
      r = $urandom_range(99);
      if (r < 60) t = $urandom_range(524287) - 262144;
      else if (r < 80) t = $urandom_range(33554431) - 16777216;
      else if (r < 95) t = $urandom;
      else t = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      push_cmd(a, t);
    end
  endtask

  // wait out every result, then the longest back end pass
  task automatic drain_all;
    while (reports_checked < cmds_queued) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_PROP_GAIN:  g_kp = $signed(data[15:0]);
      CFG_INTEG_GAIN: g_ki = $signed(data[15:0]);
      CFG_DERIV_GAIN: g_kd = $signed(data[15:0]);
      CFG_PULSE_STEP: g_step = data[15:0];
      CFG_DEAD_BAND:  g_band = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_servo(input int kp, input int ki, input int kd,
                           input int unsigned step, input int unsigned band);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_PULSE_STEP, step);
    write_reg(CFG_DEAD_BAND, band);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROP_GAIN;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset gains: deadband edges, truncation, direction and error clamps
    push_cmd(ACT_CTRL, 0);
    push_cmd(ACT_CTRL, 9830);
    push_cmd(ACT_CTRL, 9831);
    push_cmd(ACT_CTRL, -9831);
    push_cmd(ACT_PULSE, 32'sh7fffffff);
    push_cmd(ACT_PULSE, 0);
    push_cmd(ACT_CTRL, 32'sh7fffffff);
    push_cmd(ACT_PULSE, 32'sh80000000);
    push_cmd(ACT_CTRL, 32'sh80000000);
    push_cmd(ACT_ZERO, 32'sh7fffffff);
    push_cmd(ACT_PULSE, 0);
    push_cmd(ACT_IDLE, 32'sh7fffffff);
    push_cmd(ACT_IDLE, 32'sh80000000);
    push_cmd(ACT_CTRL, 32'sh80000000);
    push_cmd(ACT_ZERO, 0);
    push_cmd(ACT_CTRL, 32'sh80000000);
    push_cmd(ACT_PULSE, -1);
    push_cmd(ACT_CTRL, 0);
    push_cmd(ACT_ZERO, -1);
    drain_all();

    set_servo(32767, 0, 0, 65535, 0);
    push_random(PHASE_ITEMS);
    drain_all();

    // no idling on either side for this whole phase
    calm = 1'b1;
    set_servo(-32768, -32768, 32767, 0, 32'h7fffffff);
    push_random(PHASE_ITEMS);
    drain_all();
    calm = 1'b0;

    set_servo(3, 1, -5, 1000, 300);
    push_random(PHASE_ITEMS);
    hold_go = 1'b1;
    drain_all();

    set_servo($urandom_range(2000) - 1000, $urandom_range(100) - 50,
              $urandom_range(4000) - 2000, $urandom_range(65535), $urandom_range(1048575));
    push_random(PHASE_ITEMS);
    drain_all();

    set_servo(1, 32767, -32768, 1, 65536);
    push_random(PHASE_ITEMS);
    drain_all();

    set_servo($urandom, $urandom, $urandom, $urandom, $urandom);
    push_random(PHASE_ITEMS);
    drain_all();

    set_servo(200, 0, 0, 367, 9830);
    push_random(PHASE_ITEMS);
    drain_all();

    // build up a large integral inside a full deadband
    set_servo(200, 0, 0, 367, 32'h7fffffff);
    push_cmd(ACT_ZERO, 0);
    push_repeat(ACT_CTRL, 32'sh7fffffff, 20);
    drain_all();

    // large integral against a full-scale derivative term
    set_servo(0, 1, -32768, 367, 0);
    push_cmd(ACT_ZERO, 0);
    push_cmd(ACT_CTRL, 32'sh80000000);
    push_cmd(ACT_CTRL, 32'sh7fffffff);
    drain_all();

    // walk the position both ways at the largest step
    set_servo(200, 0, 0, 65535, 9830);
    push_cmd(ACT_ZERO, 0);
    push_repeat(ACT_PULSE, 0, 20);
    push_cmd(ACT_CTRL, 32'sh80000000);
    push_cmd(ACT_ZERO, 0);
    push_repeat(ACT_PULSE, 0, 20);
    push_cmd(ACT_CTRL, 32'sh7fffffff);
    push_random(40);
    drain_all();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pmd_pkg.sv
sv/pmd_front.sv
sv/pmd_back.sv
sv/position_pid_motor_drive.sv
sim/position_pid_motor_drive_test.sv
